// ===== rtl/cphc_pkg.sv =====
// Package for the half-plane polygon clipper.
// Holds field widths, register indexes, reset values and the sequencer state type.
// Used by the channel interfaces and by the top level.
package cphc_pkg;

    localparam int COORD_W  = 24;
    localparam int MARGIN_W = 20;
    localparam int SIDE_W   = 52;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_END_X   = 3'd2,
        CFG_END_Y   = 3'd3,
        CFG_MARGIN  = 3'd4
    } cfg_idx_t;

    localparam logic signed [COORD_W-1:0] RST_START_X = 24'sd0;
    localparam logic signed [COORD_W-1:0] RST_START_Y = 24'sd0;
    localparam logic signed [COORD_W-1:0] RST_END_X   = 24'sd256;
    localparam logic signed [COORD_W-1:0] RST_END_Y   = 24'sd0;
    localparam logic [MARGIN_W-1:0]       RST_MARGIN  = 20'd0;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SLOAD = 13'b0000000000010,
        ST_SMUL  = 13'b0000000000100,
        ST_SACC  = 13'b0000000001000,
        ST_EVAL  = 13'b0000000010000,
        ST_SLOT  = 13'b0000000100000,
        ST_XSET  = 13'b0000001000000,
        ST_XABS  = 13'b0000010000000,
        ST_XMUL  = 13'b0000100000000,
        ST_XNUM  = 13'b0001000000000,
        ST_XDIV  = 13'b0010000000000,
        ST_XFIN  = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

endpackage

// ===== rtl/cphc_ifs.sv =====
// Channel interfaces of the half-plane polygon clipper: vertex input,
// result output and configuration write. Depends on cphc_pkg.
interface cphc_vertex_if import cphc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  vertex_x;
    logic signed [COORD_W-1:0]  vertex_y;
    logic                       final_vertex;
    modport source (output valid, output vertex_x, output vertex_y, output final_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input final_vertex,
                  output ready);
endinterface

interface cphc_result_if import cphc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic                       out_valid;
    logic                       is_crossing;
    logic                       run_last;
    logic                       polygon_done;
    modport source (output valid, output out_x, output out_y, output out_valid,
                    output is_crossing, output run_last, output polygon_done,
                    input ready);
    modport sink (input valid, input out_x, input out_y, input out_valid,
                  input is_crossing, input run_last, input polygon_done,
                  output ready);
endinterface

interface cphc_cfg_if import cphc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [COORD_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/convex_polygon_halfplane_clip.sv =====
// Half-plane polygon clipper, one vertex per input transfer, up to three results each.
// The side value is built from 4 serial products, then each crossing computes its
// 2 coordinates in turn (25-step shift-add multiply, 80-step divider for each).
// The pace is set by the shared shift-add multiplier and the one-bit-per-cycle restoring
// divider; one item is in work at a time.
// Reset (rst_n low, asynchronous) restores the line registers and waits for a first vertex.
module convex_polygon_halfplane_clip import cphc_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    cphc_vertex_if.sink     vin,
    cphc_result_if.source   vout,
    cphc_cfg_if.sink        cfg
);

    localparam int PW = 78;          // product width
    localparam int MPW = 25;         // multiplier operand width
    localparam int NW = 80;          // dividend width
    localparam int DW = SIDE_W + 1;  // side difference width
    localparam int RW = DW + 1;      // remainder width
    localparam int QW = 27;          // kept quotient bits
    localparam logic [6:0] DIV_LAST = 7'(NW - 1);
    localparam logic [4:0] MUL_LAST = 5'(MPW - 1);
    localparam logic [QW-1:0] MAG_MAX = 27'd33554432;
    localparam logic signed [27:0] SAT_MAX = 28'sd8388607;
    localparam logic signed [27:0] SAT_MIN = -28'sd8388608;

    // magnitude and inside-test helpers
    function automatic logic [MPW-1:0] abs25(input logic signed [MPW-1:0] v);
        abs25 = v[MPW-1] ? MPW'(-v) : MPW'(v);
    endfunction

    function automatic logic inside_of(input logic signed [SIDE_W-1:0] s,
                                       input logic [MARGIN_W-1:0] m);
        logic signed [SIDE_W:0] t;
        t = {s[SIDE_W-1], s} + $signed({{(SIDE_W+1-MARGIN_W){1'b0}}, m});
        inside_of = t[SIDE_W];
    endfunction

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [MARGIN_W-1:0]       margin_reg;

    logic signed [COORD_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic                      fin_reg, fin_next;
    logic signed [SIDE_W-1:0]  s_reg, s_next;
    logic [1:0]                step_reg, step_next;

    logic [PW-1:0]  mc_reg, mc_next, prod_reg, prod_next;
    logic [MPW-1:0] mp_reg, mp_next;
    logic           msign_reg, msign_next;
    logic [4:0]     mcnt_reg, mcnt_next;

    logic signed [COORD_W-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [SIDE_W-1:0]  first_side_reg, first_side_next;
    logic signed [SIDE_W-1:0]  prev_side_reg, prev_side_next;
    logic                      have_first_reg, have_first_next;

    logic [4:0] slot_en_reg, slot_en_next;
    logic [2:0] slot_reg, slot_next;

    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [SIDE_W-1:0]  tp_reg, tp_next, tq_reg, tq_next;
    logic                      coord_reg, coord_next;
    logic signed [COORD_W:0]   diff_reg, diff_next;
    logic signed [DW-1:0]      den_reg, den_next;
    logic [DW-1:0]             ad_reg, ad_next;
    logic                      neg_reg, neg_next;

    logic [NW-1:0] num_reg, num_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic          qovf_reg, qovf_next;
    logic [6:0]    dcnt_reg, dcnt_next;

    logic signed [COORD_W-1:0] rx_reg, rx_next, ry_reg, ry_next;

    logic                      ov_reg, ov_next;
    logic signed [COORD_W-1:0] o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic                      o_valid_reg, o_valid_next, o_cross_reg, o_cross_next;
    logic                      o_last_reg, o_last_next, o_done_reg, o_done_next;

    // shared combinational terms
    logic signed [MPW-1:0]   op1;
    logic signed [COORD_W-1:0] op2;
    logic                    qin, pin, fin_in, later;
    logic [RW:0]             dtrial;
    logic                    dge;
    logic [QW-1:0]           mag;
    logic signed [27:0]      rsum;
    logic signed [COORD_W-1:0] rsat, p_sel;

    assign vin.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign vout.valid        = ov_reg;
    assign vout.out_x        = o_x_reg;
    assign vout.out_y        = o_y_reg;
    assign vout.out_valid    = o_valid_reg;
    assign vout.is_crossing  = o_cross_reg;
    assign vout.run_last     = o_last_reg;
    assign vout.polygon_done = o_done_reg;

    // write the line registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg     <= RST_START_X;
            sy_reg     <= RST_START_Y;
            ex_reg     <= RST_END_X;
            ey_reg     <= RST_END_Y;
            margin_reg <= RST_MARGIN;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_START_X: sx_reg     <= $signed(cfg.data);
                CFG_START_Y: sy_reg     <= $signed(cfg.data);
                CFG_END_X:   ex_reg     <= $signed(cfg.data);
                CFG_END_Y:   ey_reg     <= $signed(cfg.data);
                CFG_MARGIN:  margin_reg <= cfg.data[MARGIN_W-1:0];
                default:     ;
            endcase
        end
    end

    // pick the operands of one side-value term
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op1 = {sy_reg[COORD_W-1], sy_reg} - {ey_reg[COORD_W-1], ey_reg};
                op2 = vx_reg;
            end
            2'd1:
            begin
                op1 = {ex_reg[COORD_W-1], ex_reg} - {sx_reg[COORD_W-1], sx_reg};
                op2 = vy_reg;
            end
            2'd2:
            begin
                op1 = {sx_reg[COORD_W-1], sx_reg};
                op2 = ey_reg;
            end
            default:
            begin
                op1 = {sy_reg[COORD_W-1], sy_reg};
                op2 = ex_reg;
            end
        endcase
    end

    // inside tests and the divider and saturation datapath
    always_comb
    begin
        qin    = inside_of(s_reg, margin_reg);
        pin    = inside_of(prev_side_reg, margin_reg);
        fin_in = inside_of(have_first_reg ? first_side_reg : s_reg, margin_reg);
        later  = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            if (k > int'(slot_reg) && slot_en_reg[k])
                later = 1'b1;
        end
        dtrial = {rem_reg, num_reg[NW-1]};
        dge    = dtrial >= {1'b0, ad_reg, 1'b0};
        mag    = (qovf_reg || quo_reg > MAG_MAX) ? MAG_MAX : quo_reg;
        p_sel  = coord_reg ? py_reg : px_reg;
        rsum   = neg_reg ? ({{4{p_sel[COORD_W-1]}}, p_sel} - $signed({1'b0, mag}))
                         : ({{4{p_sel[COORD_W-1]}}, p_sel} + $signed({1'b0, mag}));
        if (rsum > SAT_MAX)
            rsat = SAT_MAX[COORD_W-1:0];
        else if (rsum < SAT_MIN)
            rsat = SAT_MIN[COORD_W-1:0];
        else
            rsat = rsum[COORD_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        fin_next        = fin_reg;
        s_next          = s_reg;
        step_next       = step_reg;
        mc_next         = mc_reg;
        mp_next         = mp_reg;
        prod_next       = prod_reg;
        msign_next      = msign_reg;
        mcnt_next       = mcnt_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        first_side_next = first_side_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_side_next  = prev_side_reg;
        have_first_next = have_first_reg;
        slot_en_next    = slot_en_reg;
        slot_next       = slot_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        tp_next         = tp_reg;
        tq_next         = tq_reg;
        coord_next      = coord_reg;
        diff_next       = diff_reg;
        den_next        = den_reg;
        ad_next         = ad_reg;
        neg_next        = neg_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        qovf_next       = qovf_reg;
        dcnt_next       = dcnt_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        ov_next         = ov_reg && !vout.ready;
        o_x_next        = o_x_reg;
        o_y_next        = o_y_reg;
        o_valid_next    = o_valid_reg;
        o_cross_next    = o_cross_reg;
        o_last_next     = o_last_reg;
        o_done_next     = o_done_reg;

        // advance the shift-add multiplier
        if (state_reg == ST_SMUL || state_reg == ST_XMUL)
        begin
            if (mp_reg[0])
                prod_next = prod_reg + mc_reg;
            mc_next   = {mc_reg[PW-2:0], 1'b0};
            mp_next   = {1'b0, mp_reg[MPW-1:1]};
            mcnt_next = mcnt_reg + 5'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (vin.valid)
                begin
                    vx_next    = vin.vertex_x;
                    vy_next    = vin.vertex_y;
                    fin_next   = vin.final_vertex;
                    s_next     = '0;
                    step_next  = 2'd0;
                    state_next = ST_SLOAD;
                end
            end
            ST_SLOAD:
            begin
                msign_next = op1[MPW-1] ^ op2[COORD_W-1] ^ (step_reg == 2'd3);
                mc_next    = PW'(abs25(op1));
                mp_next    = abs25({op2[COORD_W-1], op2});
                prod_next  = '0;
                mcnt_next  = '0;
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                if (mcnt_reg == MUL_LAST)
                    state_next = ST_SACC;
            end
            ST_SACC:
            begin
                s_next = msign_reg ? s_reg - $signed(prod_reg[SIDE_W-1:0])
                                   : s_reg + $signed(prod_reg[SIDE_W-1:0]);
                step_next  = step_reg + 2'd1;
                state_next = (step_reg == 2'd3) ? ST_EVAL : ST_SLOAD;
            end
            ST_EVAL:
            begin
                // decide which results this vertex gives
                slot_en_next[0] = have_first_reg && (pin != qin);
                slot_en_next[1] = have_first_reg && qin;
                slot_en_next[2] = fin_reg && (qin != fin_in);
                slot_en_next[3] = fin_reg && fin_in;
                slot_en_next[4] = fin_reg && !(have_first_reg && (pin != qin))
                                  && !(have_first_reg && qin) && !(qin != fin_in) && !fin_in;
                if (!have_first_reg)
                begin
                    first_x_next    = vx_reg;
                    first_y_next    = vy_reg;
                    first_side_next = s_reg;
                end
                slot_next  = 3'd0;
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                if (slot_reg == 3'd5)
                begin
                    prev_x_next     = vx_reg;
                    prev_y_next     = vy_reg;
                    prev_side_next  = s_reg;
                    have_first_next = !fin_reg;
                    slot_en_next    = '0;
                    state_next      = ST_IDLE;
                end
                else if (!slot_en_reg[slot_reg])
                    slot_next = slot_reg + 3'd1;
                else
                begin
                    case (slot_reg)
                        3'd0:
                        begin
                            px_next = prev_x_reg;
                            py_next = prev_y_reg;
                            tp_next = prev_side_reg;
                            qx_next = vx_reg;
                            qy_next = vy_reg;
                            tq_next = s_reg;
                            coord_next = 1'b0;
                            state_next = ST_XSET;
                        end
                        3'd2:
                        begin
                            px_next = vx_reg;
                            py_next = vy_reg;
                            tp_next = s_reg;
                            qx_next = first_x_reg;
                            qy_next = first_y_reg;
                            tq_next = first_side_reg;
                            coord_next = 1'b0;
                            state_next = ST_XSET;
                        end
                        3'd1:
                        begin
                            rx_next = vx_reg;
                            ry_next = vy_reg;
                            state_next = ST_EMIT;
                        end
                        3'd3:
                        begin
                            rx_next = first_x_reg;
                            ry_next = first_y_reg;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            rx_next = '0;
                            ry_next = '0;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_XSET:
            begin
                diff_next = coord_reg
                          ? ({py_reg[COORD_W-1], py_reg} - {qy_reg[COORD_W-1], qy_reg})
                          : ({px_reg[COORD_W-1], px_reg} - {qx_reg[COORD_W-1], qx_reg});
                den_next  = {tq_reg[SIDE_W-1], tq_reg} - {tp_reg[SIDE_W-1], tp_reg};
                state_next = ST_XABS;
            end
            ST_XABS:
            begin
                ad_next    = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
                neg_next   = tp_reg[SIDE_W-1] ^ diff_reg[COORD_W] ^ den_reg[DW-1];
                mc_next    = tp_reg[SIDE_W-1] ? PW'(SIDE_W'(-tp_reg)) : PW'(SIDE_W'(tp_reg));
                mp_next    = abs25(diff_reg);
                prod_next  = '0;
                mcnt_next  = '0;
                state_next = ST_XMUL;
            end
            ST_XMUL:
            begin
                if (mcnt_reg == MUL_LAST)
                    state_next = ST_XNUM;
            end
            ST_XNUM:
            begin
                num_next   = {1'b0, prod_reg, 1'b0} + NW'(ad_reg);
                rem_next   = '0;
                quo_next   = '0;
                qovf_next  = 1'b0;
                dcnt_next  = '0;
                state_next = ST_XDIV;
            end
            ST_XDIV:
            begin
                // one quotient bit per cycle, rounding folded into the dividend
                rem_next  = dge ? RW'(dtrial - {1'b0, ad_reg, 1'b0}) : RW'(dtrial);
                num_next  = {num_reg[NW-2:0], 1'b0};
                qovf_next = qovf_reg | quo_reg[QW-1];
                quo_next  = {quo_reg[QW-2:0], dge};
                dcnt_next = dcnt_reg + 7'd1;
                if (dcnt_reg == DIV_LAST)
                    state_next = ST_XFIN;
            end
            ST_XFIN:
            begin
                if (coord_reg)
                begin
                    ry_next    = rsat;
                    state_next = ST_EMIT;
                end
                else
                begin
                    rx_next    = rsat;
                    coord_next = 1'b1;
                    state_next = ST_XSET;
                end
            end
            ST_EMIT:
            begin
                // load the output register once it is free
                if (!ov_reg || vout.ready)
                begin
                    ov_next      = 1'b1;
                    o_x_next     = rx_reg;
                    o_y_next     = ry_reg;
                    o_valid_next = (slot_reg != 3'd4);
                    o_cross_next = (slot_reg == 3'd0) || (slot_reg == 3'd2);
                    o_last_next  = !later;
                    o_done_next  = fin_reg && !later;
                    slot_next    = slot_reg + 3'd1;
                    state_next   = ST_SLOT;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_first_reg  <= 1'b0;
            slot_en_reg     <= '0;
            slot_reg        <= '0;
            ov_reg          <= 1'b0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            first_side_reg  <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_side_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            have_first_reg  <= have_first_next;
            slot_en_reg     <= slot_en_next;
            slot_reg        <= slot_next;
            ov_reg          <= ov_next;
            first_x_reg     <= first_x_next;
            first_y_reg     <= first_y_next;
            first_side_reg  <= first_side_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            prev_side_reg   <= prev_side_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        fin_reg     <= fin_next;
        s_reg       <= s_next;
        step_reg    <= step_next;
        mc_reg      <= mc_next;
        mp_reg      <= mp_next;
        prod_reg    <= prod_next;
        msign_reg   <= msign_next;
        mcnt_reg    <= mcnt_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        tp_reg      <= tp_next;
        tq_reg      <= tq_next;
        coord_reg   <= coord_next;
        diff_reg    <= diff_next;
        den_reg     <= den_next;
        ad_reg      <= ad_next;
        neg_reg     <= neg_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        qovf_reg    <= qovf_next;
        dcnt_reg    <= dcnt_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        o_x_reg     <= o_x_next;
        o_y_reg     <= o_y_next;
        o_valid_reg <= o_valid_next;
        o_cross_reg <= o_cross_next;
        o_last_reg  <= o_last_next;
        o_done_reg  <= o_done_next;
    end

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (vout.valid && vout.polygon_done) |-> vout.run_last)
        else $error("polygon end without run end");

    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (vout.valid && !vout.out_valid) |->
        (vout.out_x == '0 && vout.out_y == '0 && !vout.is_crossing && vout.polygon_done))
        else $error("malformed end marker");

    a_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (vin.valid && vin.ready) |-> (slot_en_reg == '0))
        else $error("vertex accepted with results pending");
`endif

endmodule
